// ----- rtl/fcc_pkg.sv -----
// Shared constants and types for the floor texture coordinate caster.
// No dependencies.
package fcc_pkg;

  localparam int CfgW   = 27;
  localparam int CfgAW  = 3;
  localparam int PosW   = 27;
  localparam int VecW   = 16;
  localparam int ScrW   = 13;
  localparam int RowW   = 11;
  localparam int ColW   = 12;
  localparam int TexW   = 6;
  localparam int FracW  = 16;
  localparam int RW     = 15;  // row times the largest row step
  localparam int DivW   = RW + ScrW;
  localparam int SumW   = 32;
  localparam int NumW   = 47;
  localparam int TexPW  = FracW + 11;
  localparam int FrontStages = 4;
  localparam int InDataW  = 24;
  localparam int OutDataW = 16;

  localparam int DefRowStep   = 1;
  localparam int DefTexWidth  = 64;
  localparam int DefTexHeight = 64;

  localparam logic [CfgAW-1:0] RegPosX   = 3'd0;
  localparam logic [CfgAW-1:0] RegPosY   = 3'd1;
  localparam logic [CfgAW-1:0] RegDirX   = 3'd2;
  localparam logic [CfgAW-1:0] RegDirY   = 3'd3;
  localparam logic [CfgAW-1:0] RegPlaneX = 3'd4;
  localparam logic [CfgAW-1:0] RegPlaneY = 3'd5;
  localparam logic [CfgAW-1:0] RegWidth  = 3'd6;
  localparam logic [CfgAW-1:0] RegHeight = 3'd7;

  typedef struct packed {
    logic [NumW-1:0] mag;
    logic            neg;
  } fcc_num_t;

  typedef struct packed {
    logic [FracW-1:0] q;
    logic             rem_nz;
    logic             neg;
  } fcc_quot_t;

endpackage

// ----- rtl/floor_texture_coordinate_caster.sv -----
// Floor texture coordinate caster: one floor pixel request in, one texel
// coordinate result out, one request per cycle sustained while m_tready does
// not stall it. Path: product registers, 47 divider stages (one quotient bit
// each) and the output register. Row zero returns a saturated flag, zero texels.
module floor_texture_coordinate_caster import fcc_pkg::*; #(
  parameter int ROW_STEP   = DefRowStep,
  parameter int TEX_WIDTH  = DefTexWidth,
  parameter int TEX_HEIGHT = DefTexHeight
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgAW-1:0]    cfg_addr,
  input  logic [CfgW-1:0]     cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // row_index, column_index, zero pad
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [OutDataW-1:0] m_tdata,   // tex_x, tex_y, zero pad
  output logic                m_tuser    // horizon_saturated
);

  localparam int Lat = FrontStages + NumW;

  logic [PosW-1:0]        pos_x, pos_y;
  logic signed [VecW-1:0] dir_x, dir_y, plane_x, plane_y;
  logic [ScrW-1:0]        screen_width, screen_height;

  logic            en;
  logic [Lat-1:0]  vld;
  logic [Lat-1:0]  sat;
  fcc_num_t        num_x, num_y;
  logic [DivW-1:0] divisor;
  fcc_quot_t       quot_x, quot_y;
  logic [TexW-1:0] tex_x, tex_y;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x         <= '0;
      pos_y         <= '0;
      dir_x         <= 16'sd16384;
      dir_y         <= '0;
      plane_x       <= '0;
      plane_y       <= 16'sd10813;
      screen_width  <= 13'd640;
      screen_height <= 13'd480;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegPosX:   pos_x         <= cfg_data[PosW-1:0];
        RegPosY:   pos_y         <= cfg_data[PosW-1:0];
        RegDirX:   dir_x         <= cfg_data[VecW-1:0];
        RegDirY:   dir_y         <= cfg_data[VecW-1:0];
        RegPlaneX: plane_x       <= cfg_data[VecW-1:0];
        RegPlaneY: plane_y       <= cfg_data[VecW-1:0];
        RegWidth:  screen_width  <= cfg_data[ScrW-1:0];
        RegHeight: screen_height <= cfg_data[ScrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[Lat-2:0], s_tvalid};
      m_tvalid <= vld[Lat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat     <= {sat[Lat-2:0], s_tdata[RowW-1:0] == '0};
      m_tuser <= sat[Lat-1];
      m_tdata <= sat[Lat-1] ? '0 : OutDataW'({tex_y, tex_x});
    end
  end

  fcc_front #(.ROW_STEP(ROW_STEP)) u_front (
    .clk           (clk),
    .en            (en),
    .row_index     (s_tdata[RowW-1:0]),
    .column_index  (s_tdata[RowW +: ColW]),
    .dir_x         (dir_x),
    .dir_y         (dir_y),
    .plane_x       (plane_x),
    .plane_y       (plane_y),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .num_x         (num_x),
    .num_y         (num_y),
    .divisor       (divisor)
  );

  fcc_div u_div_x (
    .clk     (clk),
    .en      (en),
    .num     (num_x),
    .divisor (divisor),
    .quot    (quot_x)
  );

  fcc_div u_div_y (
    .clk     (clk),
    .en      (en),
    .num     (num_y),
    .divisor (divisor),
    .quot    (quot_y)
  );

  fcc_back #(.TEX_SIZE(TEX_WIDTH)) u_back_x (
    .quot (quot_x),
    .pos  (pos_x),
    .tex  (tex_x)
  );

  fcc_back #(.TEX_SIZE(TEX_HEIGHT)) u_back_y (
    .quot (quot_y),
    .pos  (pos_y),
    .tex  (tex_y)
  );

endmodule

// ----- rtl/fcc_front.sv -----
// Front pipeline: numerator products, eye-height scaling and sign split.
// Depends on fcc_pkg.
module fcc_front import fcc_pkg::*; #(
  parameter int ROW_STEP = DefRowStep
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [RowW-1:0]        row_index,
  input  logic [ColW-1:0]        column_index,
  input  logic signed [VecW-1:0] dir_x,
  input  logic signed [VecW-1:0] dir_y,
  input  logic signed [VecW-1:0] plane_x,
  input  logic signed [VecW-1:0] plane_y,
  input  logic [ScrW-1:0]        screen_width,
  input  logic [ScrW-1:0]        screen_height,
  output fcc_num_t               num_x,
  output fcc_num_t               num_y,
  output logic [DivW-1:0]        divisor
);

  logic [ScrW-1:0]        w_eff;
  logic [RW-1:0]          r;
  logic signed [VecW:0]   dp_x, dp_y;
  logic signed [ScrW:0]   w_s, c2_s;
  logic signed [SumW-1:0] a_x, a_y, b_x, b_y;
  logic signed [SumW-1:0] s_x, s_y;
  logic signed [NumW-1:0] n_x, n_y;
  logic signed [ScrW+1:0] h2_s;
  logic [DivW-1:0]        d1, d2, d3;

  assign w_eff = (screen_width == '0) ? ScrW'(1) : screen_width;
  assign r     = RW'(row_index) * RW'(ROW_STEP);
  assign dp_x  = (VecW+1)'(dir_x) - (VecW+1)'(plane_x);
  assign dp_y  = (VecW+1)'(dir_y) - (VecW+1)'(plane_y);
  assign w_s   = signed'({1'b0, w_eff});
  assign c2_s  = signed'({1'b0, column_index, 1'b0});
  assign h2_s  = signed'({1'b0, screen_height, 1'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      a_x <= SumW'(dp_x * w_s);
      a_y <= SumW'(dp_y * w_s);
      b_x <= SumW'(c2_s * plane_x);
      b_y <= SumW'(c2_s * plane_y);
      d1  <= DivW'(r) * DivW'(w_eff);
      s_x <= a_x + b_x;
      s_y <= a_y + b_y;
      d2  <= d1;
      n_x <= NumW'(s_x * h2_s);
      n_y <= NumW'(s_y * h2_s);
      d3  <= d2;
      num_x.neg <= n_x[NumW-1];
      num_y.neg <= n_y[NumW-1];
      num_x.mag <= n_x[NumW-1] ? NumW'(-n_x) : NumW'(n_x);
      num_y.mag <= n_y[NumW-1] ? NumW'(-n_y) : NumW'(n_y);
      divisor   <= d3;
    end
  end

endmodule

// ----- rtl/fcc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Keeps the low quotient bits and a nonzero-remainder flag. Depends on fcc_pkg.
module fcc_div import fcc_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  fcc_num_t        num,
  input  logic [DivW-1:0] divisor,
  output fcc_quot_t       quot
);

  logic [NumW-1:0]  rem [0:NumW];
  logic [FracW-1:0] q   [0:NumW];
  logic [DivW-1:0]  d   [0:NumW];
  logic             neg [0:NumW];

  assign rem[0] = num.mag;
  assign q[0]   = '0;
  assign d[0]   = divisor;
  assign neg[0] = num.neg;

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    localparam int Bit = NumW - 1 - k;
    logic [NumW-1:0]  hi;
    logic             ge;
    logic [FracW-1:0] qn;

    assign hi = rem[k] >> Bit;
    assign ge = hi >= NumW'(d[k]);

    if (Bit < FracW) begin : g_keep
      always_comb begin
        qn = q[k];
        qn[Bit] = ge;
      end
    end else begin : g_drop
      assign qn = q[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - (NumW'(d[k]) << Bit) : rem[k];
        q[k+1]   <= qn;
        d[k+1]   <= d[k];
        neg[k+1] <= neg[k];
      end
    end
  end

  assign quot.q      = q[NumW];
  assign quot.rem_nz = rem[NumW] != '0;
  assign quot.neg    = neg[NumW];

endmodule

// ----- rtl/fcc_back.sv -----
// Back end: floor correction, position add and texel scaling for one axis.
// Depends on fcc_pkg.
module fcc_back import fcc_pkg::*; #(
  parameter int TEX_SIZE = DefTexWidth
) (
  input  fcc_quot_t        quot,
  input  logic [PosW-1:0]  pos,
  output logic [TexW-1:0]  tex
);

  logic [FracW-1:0] off;
  logic [FracW-1:0] frac;
  logic [TexPW-1:0] prod;

  assign off  = quot.neg ? FracW'(0) - (quot.q + FracW'(quot.rem_nz)) : quot.q;
  assign frac = pos[FracW-1:0] + off;
  assign prod = TexPW'(frac) * TexPW'(TEX_SIZE);
  assign tex  = prod[FracW +: TexW];

endmodule

// ----- verif/testbench.sv -----
// Testbench for floor_texture_coordinate_caster: directed table, register extremes, random
// pixel requests, each result checked against an in-bench floor-casting predictor. Depends
// on rtl/fcc_pkg.sv and the block itself.
module testbench;
  import fcc_pkg::*;

  localparam int Latency = 52;
  localparam int WatchdogLimit = 20000;

  typedef struct {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    bit              known;
    logic [TexW-1:0] tx;
    logic [TexW-1:0] ty;
    logic            sat;
  } pixel_row_t;

  typedef struct {
    logic [TexW-1:0] tx;
    logic [TexW-1:0] ty;
    logic            sat;
  } texel_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CfgAW-1:0] cfg_addr = '0;
  logic [CfgW-1:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tready = 0;
  logic m_tvalid;
  logic [OutDataW-1:0] m_tdata;
  logic m_tuser;

  floor_texture_coordinate_caster dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  logic signed [PosW-1:0] cam_px, cam_py;
  logic signed [VecW-1:0] cam_dx, cam_dy, cam_plx, cam_ply;
  logic [ScrW-1:0] scr_w, scr_h;

  texel_t texel_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit draining = 0;

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic logic [TexW-1:0] axis_texel(logic signed [PosW-1:0] p0,
      logic signed [VecW-1:0] d, logic signed [VecW-1:0] pl, longint r, longint c);
    longint w, h, num, off, sum;
    w = (scr_w == 0) ? longint'(1) : longint'(scr_w);
    h = longint'(scr_h);
    num = 2 * h * ((longint'(d) - longint'(pl)) * w + 2 * c * longint'(pl));
    off = floor_quot(num, r * w);
    sum = longint'(p0) + off;
    return TexW'(((sum & 64'hFFFF) * DefTexWidth) >> 16);
  endfunction

  function automatic texel_t cast_floor(logic [RowW-1:0] row, logic [ColW-1:0] col);
    texel_t t;
    longint r;
    r = longint'(row) * DefRowStep;
    if (r == 0) begin
      t.tx = '0; t.ty = '0; t.sat = 1'b1;
    end else begin
      t.tx = axis_texel(cam_px, cam_dx, cam_plx, r, longint'(col));
      t.ty = axis_texel(cam_py, cam_dy, cam_ply, r, longint'(col));
      t.sat = 1'b0;
    end
    return t;
  endfunction

  task automatic write_reg(logic [CfgAW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      RegPosX:   cam_px = val;
      RegPosY:   cam_py = val;
      RegDirX:   cam_dx = val[VecW-1:0];
      RegDirY:   cam_dy = val[VecW-1:0];
      RegPlaneX: cam_plx = val[VecW-1:0];
      RegPlaneY: cam_ply = val[VecW-1:0];
      RegWidth:  scr_w = val[ScrW-1:0];
      RegHeight: scr_h = val[ScrW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (texel_queue.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one request; expectation is queued at the accepting edge
  task automatic send_pixel(logic [RowW-1:0] row, logic [ColW-1:0] col, bit known,
      texel_t want);
    texel_t t;
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= InDataW'({col, row});
    t = cast_floor(row, col);
    if (known && (t.tx !== want.tx || t.ty !== want.ty || t.sat !== want.sat)) begin
      $display("%0t table row disagrees with predictor: exp %p got %p", $time, want, t);
      errors++;
    end
    do @(posedge clk); while (!s_tready);
    texel_queue.push_back(t);
  endtask

  task automatic random_config(int mode);
    write_reg(RegPosX, CfgW'($urandom));
    write_reg(RegPosY, CfgW'($urandom));
    write_reg(RegDirX, CfgW'($urandom_range(0, 65535)));
    write_reg(RegDirY, CfgW'($urandom_range(0, 65535)));
    write_reg(RegPlaneX, CfgW'($urandom_range(0, 65535)));
    write_reg(RegPlaneY, CfgW'($urandom_range(0, 65535)));
    case (mode)
      0: begin write_reg(RegWidth, CfgW'(1)); write_reg(RegHeight, CfgW'(2)); end
      1: begin write_reg(RegWidth, CfgW'(4096)); write_reg(RegHeight, CfgW'(4096)); end
      2: begin
        write_reg(RegWidth, CfgW'(0));
        write_reg(RegHeight, CfgW'($urandom_range(0, 1)));
      end
      3: begin write_reg(RegWidth, CfgW'(8191)); write_reg(RegHeight, CfgW'(8191)); end
      default: begin
        write_reg(RegWidth, CfgW'($urandom_range(1, 4096)));
        write_reg(RegHeight, CfgW'($urandom_range(2, 4096)));
      end
    endcase
  endtask

  // result side: random stalls, compare against oldest expectation
  always @(posedge clk) begin
    texel_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (texel_queue.size() == 0) begin
          $display("%0t unexpected result: got %h user %b", $time, m_tdata, m_tuser);
          errors++;
        end else begin
          e = texel_queue.pop_front();
          if (m_tdata[TexW-1:0] !== e.tx) begin
            $display("%0t tex_x: exp %0d got %0d", $time, e.tx, m_tdata[TexW-1:0]);
            errors++;
          end
          if (m_tdata[2*TexW-1:TexW] !== e.ty) begin
            $display("%0t tex_y: exp %0d got %0d", $time, e.ty, m_tdata[2*TexW-1:TexW]);
            errors++;
          end
          if (m_tdata[OutDataW-1:2*TexW] !== '0) begin
            $display("%0t pad: exp 0 got %h", $time, m_tdata[OutDataW-1:2*TexW]);
            errors++;
          end
          if (m_tuser !== e.sat) begin
            $display("%0t horizon_saturated: exp %b got %b", $time, e.sat, m_tuser);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready <= 1'b1;
        stall_left <= gap_len();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else if (!draining || texel_queue.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("** floor_texture_coordinate_caster: FAILED **");
      $finish;
    end
  end

  pixel_row_t stim[$];

  initial begin
    texel_t want;
    pixel_row_t pr;
    cam_px = 0; cam_py = 0; cam_dx = 16384; cam_dy = 0;
    cam_plx = 0; cam_ply = 10813; scr_w = 640; scr_h = 480;
    // row, col, known, tex_x, tex_y, sat
    stim.push_back('{11'd0, 12'd0, 1'b1, 6'd0, 6'd0, 1'b1});
    stim.push_back('{11'd0, 12'd4095, 1'b1, 6'd0, 6'd0, 1'b1});
    // reset camera, col 320: x off = 2*480*16384*640/(640) -> 960*16384 Q14 = int, frac 0
    stim.push_back('{11'd1, 12'd320, 1'b1, 6'd0, 6'd0, 1'b0});
    stim.push_back('{11'd1, 12'd0, 1'b0, 6'd0, 6'd0, 1'b0});
    stim.push_back('{11'd2047, 12'd4095, 1'b0, 6'd0, 6'd0, 1'b0});
    stim.push_back('{11'd2047, 12'd0, 1'b0, 6'd0, 6'd0, 1'b0});
    stim.push_back('{11'd1, 12'd4095, 1'b0, 6'd0, 6'd0, 1'b0});
    stim.push_back('{11'd1023, 12'd2048, 1'b0, 6'd0, 6'd0, 1'b0});
    stim.push_back('{11'd7, 12'd639, 1'b0, 6'd0, 6'd0, 1'b0});
    stim.push_back('{11'd240, 12'd1, 1'b0, 6'd0, 6'd0, 1'b0});
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (stim[i]) begin
      pr = stim[i];
      want = '{pr.tx, pr.ty, pr.sat};
      send_pixel(pr.row, pr.col, pr.known, want);
    end
    s_tvalid <= 0;
    wait_idle();
    // extremes of every register
    write_reg(RegPosX, 27'h3FFFFFF); write_reg(RegPosY, 27'h4000000);
    write_reg(RegDirX, CfgW'(16'h8000)); write_reg(RegDirY, CfgW'(16'h7FFF));
    write_reg(RegPlaneX, CfgW'(16'h7FFF)); write_reg(RegPlaneY, CfgW'(16'h8000));
    write_reg(RegWidth, CfgW'(1)); write_reg(RegHeight, CfgW'(4096));
    for (int i = 0; i < 12; i++)
      send_pixel(i < 6 ? RowW'(i) : 11'd2047, i[0] ? 12'd4095 : 12'd0, 1'b0, want);
    s_tvalid <= 0;
    wait_idle();
    for (int ph = 0; ph < 10; ph++) begin
      random_config(ph);
      for (int n = 0; n < 60; n++) begin
        int k;
        logic [RowW-1:0] row;
        k = $urandom_range(0, 19);
        if (k == 0) row = '0;
        else if (k < 12) row = RowW'($urandom_range(1, 32));
        else row = RowW'($urandom);
        send_pixel(row, ColW'($urandom), 1'b0, want);
      end
      s_tvalid <= 0;
      wait_idle();
    end
    draining = 1;
    if (errors == 0) begin
      $display("** floor_texture_coordinate_caster: PASSED **");
    end else begin
      $display("** floor_texture_coordinate_caster: FAILED **");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/fcc_pkg.sv
rtl/fcc_front.sv
rtl/fcc_div.sv
rtl/fcc_back.sv
rtl/floor_texture_coordinate_caster.sv
verif/testbench.sv
